>>> sv/crast_pkg.sv
// ----------------------------------------------------------------------------
// crast_pkg
// Opcodes, color and octant constants shared by the circle rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package crast_pkg;

  localparam int unsigned COLOR_W = 4;
  localparam int unsigned OCT_W   = 3;

  localparam logic             OP_START    = 1'b0;
  localparam logic             OP_STEP     = 1'b1;
  localparam logic [COLOR_W-1:0] COLOR_RESET = 4'd4;
  localparam logic [OCT_W-1:0]   OCT_LAST    = 3'd7;

endpackage

`default_nettype wire

>>> sv/circle_rasterizer.sv
// With the emitter idle, a step's first pixel moves from its queue slot into the
//   emitter's record registers and then into the output register.
// The emitter sends one pixel per cycle while the receiver is ready; the eight
//   pixels of a step leave one at a time through the single output port.
// Start items and steps while idle produce no pixels.
// Reset: synchronous, active low; clears the drawing state (idle), empties the
//   queue and sets the pen color to 4.
// ----------------------------------------------------------------------------
// circle_rasterizer
// Midpoint circle rasterizer: front keeps the octant walk, back emits pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_rasterizer #(
  parameter int unsigned COORD_BITS = 10
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [crast_pkg::COLOR_W-1:0] cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_opcode,
  input  wire logic [COORD_BITS-1:0]         in_center_x,
  input  wire logic [COORD_BITS-1:0]         in_center_y,
  input  wire logic [COORD_BITS-1:0]         in_radius,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [COORD_BITS+1:0]       out_pixel_x,
  output logic signed [COORD_BITS+1:0]       out_pixel_y,
  output logic [crast_pkg::COLOR_W-1:0]      out_pixel_color,
  output logic [crast_pkg::OCT_W-1:0]        out_octant,
  output logic                               out_last_of_step,
  output logic                               out_last_of_circle
);

  localparam int unsigned REC_W = 4 * COORD_BITS + 2 + 1 + crast_pkg::COLOR_W;

  logic             push;
  logic [REC_W-1:0] push_data;
  logic             queue_full;
  logic             pop;
  logic             rec_valid;
  logic [REC_W-1:0] rec_data;

  crast_front #(
    .COORD_BITS (COORD_BITS),
    .REC_W      (REC_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_opcode   (in_opcode),
    .in_center_x (in_center_x),
    .in_center_y (in_center_y),
    .in_radius   (in_radius),
    .push        (push),
    .push_data   (push_data),
    .queue_full  (queue_full)
  );

  crast_fifo #(
    .WIDTH (REC_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (rec_valid),
    .pop_data  (rec_data)
  );

  crast_back #(
    .COORD_BITS (COORD_BITS),
    .REC_W      (REC_W)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .rec_valid          (rec_valid),
    .rec_data           (rec_data),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_pixel_x        (out_pixel_x),
    .out_pixel_y        (out_pixel_y),
    .out_pixel_color    (out_pixel_color),
    .out_octant         (out_octant),
    .out_last_of_step   (out_last_of_step),
    .out_last_of_circle (out_last_of_circle)
  );

endmodule

`default_nettype wire

>>> sv/crast_fifo.sv
// ----------------------------------------------------------------------------
// crast_fifo
// Two-entry queue that carries step records from the front to the back.
// ----------------------------------------------------------------------------
`default_nettype none

module crast_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int unsigned DEPTH = 2;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic             wr_ptr_r;
  logic             wr_ptr_nxt;
  logic             rd_ptr_r;
  logic             rd_ptr_nxt;
  logic [1:0]       count_r;
  logic [1:0]       count_nxt;

  assign full      = (count_r == 2'(DEPTH));
  assign not_empty = (count_r != 2'd0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> sv/crast_front.sv
// ----------------------------------------------------------------------------
// crast_front
// Accepts start and step items, keeps the midpoint state and the pen color,
// and queues one record per step of an active circle for pixel emission.
// ----------------------------------------------------------------------------
`default_nettype none

module crast_front #(
  parameter int unsigned COORD_BITS = 10,
  parameter int unsigned REC_W      = 4 * COORD_BITS + 2 + 1 + crast_pkg::COLOR_W
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [crast_pkg::COLOR_W-1:0] cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_opcode,
  input  wire logic [COORD_BITS-1:0]         in_center_x,
  input  wire logic [COORD_BITS-1:0]         in_center_y,
  input  wire logic [COORD_BITS-1:0]         in_radius,
  output logic                               push,
  output logic [REC_W-1:0]                   push_data,
  input  wire logic                          queue_full
);

  localparam int unsigned OFF_W = COORD_BITS + 1;
  localparam int unsigned PIX_W = COORD_BITS + 2;
  localparam int unsigned DEC_W = COORD_BITS + 4;

  logic [crast_pkg::COLOR_W-1:0] color_r;
  logic signed [OFF_W-1:0]       off_x_r;
  logic signed [OFF_W-1:0]       off_x_nxt;
  logic signed [OFF_W-1:0]       off_y_r;
  logic signed [OFF_W-1:0]       off_y_nxt;
  logic signed [DEC_W-1:0]       dec_r;
  logic signed [DEC_W-1:0]       dec_nxt;
  logic [COORD_BITS-1:0]         cx_r;
  logic [COORD_BITS-1:0]         cy_r;
  logic                          active_r;
  logic                          active_nxt;

  logic                          accept;
  logic signed [DEC_W-1:0]       xs;
  logic signed [DEC_W-1:0]       ys;
  logic signed [PIX_W-1:0]       x1;
  logic signed [PIX_W-1:0]       y1;
  logic                          last;

  assign in_ready = ~queue_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (in_opcode == crast_pkg::OP_STEP) && active_r;
  assign push_data = {color_r, last, cy_r, cx_r, off_y_r, off_x_r};

  // Midpoint update of the current point
  always_comb begin
    xs = DEC_W'(off_x_r);
    ys = DEC_W'(off_y_r);
    x1 = PIX_W'(off_x_r) + PIX_W'(1);
    if (dec_r[DEC_W-1]) begin
      dec_nxt = dec_r + (xs <<< 2) + DEC_W'(6);
      y1      = PIX_W'(off_y_r);
    end else begin
      dec_nxt = dec_r + ((xs - ys) <<< 2) + DEC_W'(10);
      y1      = PIX_W'(off_y_r) - PIX_W'(1);
    end
    last      = (x1 > y1);
    off_x_nxt = x1[OFF_W-1:0];
    off_y_nxt = y1[OFF_W-1:0];
    active_nxt = ~last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r  <= crast_pkg::COLOR_RESET;
      off_x_r  <= '0;
      off_y_r  <= '0;
      dec_r    <= '0;
      cx_r     <= '0;
      cy_r     <= '0;
      active_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        color_r <= cfg_wr_data;
      end
      if (accept && (in_opcode == crast_pkg::OP_START)) begin
        cx_r     <= in_center_x;
        cy_r     <= in_center_y;
        off_x_r  <= '0;
        off_y_r  <= OFF_W'(in_radius);
        dec_r    <= DEC_W'(3) - (DEC_W'(in_radius) << 1);
        active_r <= 1'b1;
      end else if (push) begin
        off_x_r  <= off_x_nxt;
        off_y_r  <= off_y_nxt;
        dec_r    <= dec_nxt;
        active_r <= active_nxt;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/crast_back.sv
// ----------------------------------------------------------------------------
// crast_back
// Takes step records from the queue and emits the eight symmetric pixels,
// one per cycle while the receiver is ready, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module crast_back #(
  parameter int unsigned COORD_BITS = 10,
  parameter int unsigned REC_W      = 4 * COORD_BITS + 2 + 1 + crast_pkg::COLOR_W
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          rec_valid,
  input  wire logic [REC_W-1:0]              rec_data,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [COORD_BITS+1:0]       out_pixel_x,
  output logic signed [COORD_BITS+1:0]       out_pixel_y,
  output logic [crast_pkg::COLOR_W-1:0]      out_pixel_color,
  output logic [crast_pkg::OCT_W-1:0]        out_octant,
  output logic                               out_last_of_step,
  output logic                               out_last_of_circle
);

  localparam int unsigned OFF_W = COORD_BITS + 1;
  localparam int unsigned PIX_W = COORD_BITS + 2;

  logic                          busy_r;
  logic                          busy_nxt;
  logic [crast_pkg::OCT_W-1:0]   oct_r;
  logic [crast_pkg::OCT_W-1:0]   oct_nxt;
  logic [crast_pkg::COLOR_W-1:0] color_r;
  logic                          last_r;
  logic [COORD_BITS-1:0]         cx_r;
  logic [COORD_BITS-1:0]         cy_r;
  logic signed [OFF_W-1:0]       x_r;
  logic signed [OFF_W-1:0]       y_r;

  logic                          out_valid_r;
  logic signed [PIX_W-1:0]       px_r;
  logic signed [PIX_W-1:0]       py_r;
  logic [crast_pkg::COLOR_W-1:0] pcol_r;
  logic [crast_pkg::OCT_W-1:0]   poct_r;
  logic                          plast_step_r;
  logic                          plast_circ_r;

  logic                          adv;
  logic                          oct_end;
  logic signed [PIX_W-1:0]       ox;
  logic signed [PIX_W-1:0]       oy;
  logic signed [PIX_W-1:0]       px;
  logic signed [PIX_W-1:0]       py;

  assign oct_end = (oct_r == crast_pkg::OCT_LAST);
  assign adv     = busy_r && (!out_valid_r || out_ready);
  // Refill on the cycle the eighth pixel moves out, so steps run back to back
  assign pop     = rec_valid && (!busy_r || (adv && oct_end));

  // Octant bits: 2 swaps the axes, 1 negates the row, 0 negates the column
  always_comb begin
    ox = oct_r[2] ? PIX_W'(y_r) : PIX_W'(x_r);
    oy = oct_r[2] ? PIX_W'(x_r) : PIX_W'(y_r);
    px = PIX_W'(cx_r) + (oct_r[0] ? -ox : ox);
    py = PIX_W'(cy_r) + (oct_r[1] ? -oy : oy);
    oct_nxt = pop ? '0 : (adv ? oct_r + crast_pkg::OCT_W'(1) : oct_r);
    if (pop) begin
      busy_nxt = 1'b1;
    end else if (adv && oct_end) begin
      busy_nxt = 1'b0;
    end else begin
      busy_nxt = busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      oct_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      oct_r  <= oct_nxt;
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      {color_r, last_r, cy_r, cx_r, y_r, x_r} <= rec_data;
    end
    if (adv) begin
      px_r         <= px;
      py_r         <= py;
      pcol_r       <= color_r;
      poct_r       <= oct_r;
      plast_step_r <= oct_end;
      plast_circ_r <= oct_end && last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pixel_x        = px_r;
  assign out_pixel_y        = py_r;
  assign out_pixel_color    = pcol_r;
  assign out_octant         = poct_r;
  assign out_last_of_step   = plast_step_r;
  assign out_last_of_circle = plast_circ_r;

endmodule

`default_nettype wire

>>> sv/crast_checker.sv
// ----------------------------------------------------------------------------
// crast_checker
// Port-level checks of the circle rasterizer output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module crast_checker #(
  parameter int unsigned COORD_BITS = 10
) (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [COORD_BITS+1:0]         out_pixel_x,
  input wire logic [COORD_BITS+1:0]         out_pixel_y,
  input wire logic [crast_pkg::OCT_W-1:0]   out_octant,
  input wire logic                          out_last_of_step,
  input wire logic                          out_last_of_circle
);

  // Hold a stalled pixel
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_x)
      && $stable(out_pixel_y) && $stable(out_octant))
    else $error("stalled pixel changed");

  a_step_mark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_of_step == (out_octant == crast_pkg::OCT_LAST)))
    else $error("last_of_step not on the eighth pixel");

  a_circle_mark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_circle |-> out_last_of_step)
    else $error("last_of_circle off a step end");

  // Within a step the pixels follow without a gap
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_step |=>
      out_valid && (out_octant == $past(out_octant) + 3'd1))
    else $error("gap or skip inside a step");

endmodule

bind circle_rasterizer crast_checker #(.COORD_BITS(COORD_BITS)) u_crast_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_pixel_x        (out_pixel_x),
  .out_pixel_y        (out_pixel_y),
  .out_octant         (out_octant),
  .out_last_of_step   (out_last_of_step),
  .out_last_of_circle (out_last_of_circle)
);

`default_nettype wire

>>> dv/circle_rasterizer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circle_rasterizer_test
// Drives start and step items into the rasterizer and checks every pixel
// against an in-bench midpoint walk: directed corners, random circles with
// random sender bursts and receiver stalls, a long output hold and pen changes.
// ----------------------------------------------------------------------------

module circle_rasterizer_test;

  localparam int unsigned COLOR_W       = crast_pkg::COLOR_W;
  localparam int unsigned OCT_W         = crast_pkg::OCT_W;
  localparam int unsigned COORD_BITS    = 10;
  localparam int unsigned OFF_W         = COORD_BITS + 1;
  localparam int unsigned DEC_W         = COORD_BITS + 4;
  localparam int unsigned PIX_W         = COORD_BITS + 2;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned CYCLE_LIMIT   = 300000;

  typedef struct packed {
    logic signed [PIX_W-1:0] pos_x;
    logic signed [PIX_W-1:0] pos_y;
    logic [COLOR_W-1:0]      color;
    logic [OCT_W-1:0]        octant;
    logic                    step_end;
    logic                    circle_end;
  } pixel_t;

  typedef enum int unsigned {SINK_FULL, SINK_RANDOM, SINK_PATTERN, SINK_SPARSE} sink_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [COLOR_W-1:0]    cfg_wr_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_opcode = crast_pkg::OP_START;
  logic [COORD_BITS-1:0] in_center_x = '0;
  logic [COORD_BITS-1:0] in_center_y = '0;
  logic [COORD_BITS-1:0] in_radius = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [PIX_W-1:0] out_pixel_x;
  logic signed [PIX_W-1:0] out_pixel_y;
  logic [COLOR_W-1:0]    out_pixel_color;
  logic [OCT_W-1:0]      out_octant;
  logic                  out_last_of_step;
  logic                  out_last_of_circle;

  // Walk state mirrored from the block
  logic [COLOR_W-1:0]        pen = crast_pkg::COLOR_RESET;
  logic signed [COORD_BITS:0]   walk_x = '0;
  logic signed [COORD_BITS:0]   walk_y = '0;
  logic signed [COORD_BITS+3:0] walk_d = '0;
  logic [COORD_BITS-1:0]     org_x = '0;
  logic [COORD_BITS-1:0]     org_y = '0;
  bit                        drawing = 1'b0;

  pixel_t pixels_due[$];

  int unsigned mismatches = 0;
  int unsigned pixels_checked = 0;
  int unsigned items_sent = 0;
  int unsigned circles_started = 0;
  int unsigned steps_drawn = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;

  // Receiver stall control
  int unsigned hold_req = 0;
  int unsigned hold_taken = 0;
  int unsigned hold_left = 0;
  sink_mode_t  sink_mode = SINK_FULL;
  int unsigned mode_left = 0;
  logic [4:0]  ready_pat = 5'b10110;

  circle_rasterizer #(.COORD_BITS(COORD_BITS)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_center_x        (in_center_x),
    .in_center_y        (in_center_y),
    .in_radius          (in_radius),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_pixel_x        (out_pixel_x),
    .out_pixel_y        (out_pixel_y),
    .out_pixel_color    (out_pixel_color),
    .out_octant         (out_octant),
    .out_last_of_step   (out_last_of_step),
    .out_last_of_circle (out_last_of_circle)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t ns: timeout with %0d pixels outstanding", $time, pixels_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Midpoint walk: a start loads the circle, a step while drawing emits eight pixels and advances
  task automatic walk_circle(input logic op, input logic [COORD_BITS-1:0] cx,
                             input logic [COORD_BITS-1:0] cy,
                             input logic [COORD_BITS-1:0] r);
    int x, y, d, ox, oy;
    int px[8];
    int py[8];
    bit done;
    pixel_t p;
    if (op == crast_pkg::OP_START) begin
      org_x  = cx;
      org_y  = cy;
      walk_x = '0;
      walk_y = OFF_W'(r);
      walk_d = DEC_W'(3 - 2 * int'(r));
      drawing = 1'b1;
      circles_started++;
    end else if (drawing) begin
      x  = int'(walk_x);
      y  = int'(walk_y);
      d  = int'(walk_d);
      ox = int'(org_x);
      oy = int'(org_y);
      px = '{ox + x, ox - x, ox + x, ox - x, ox + y, ox - y, ox + y, ox - y};
      py = '{oy + y, oy + y, oy - y, oy - y, oy + x, oy + x, oy - x, oy - x};
      if (d < 0) begin
        d = d + 4 * x + 6;
      end else begin
        d = d + 4 * (x - y) + 10;
        y = y - 1;
      end
      x = x + 1;
      done = (x > y);
      walk_x = OFF_W'(x);
      walk_y = OFF_W'(y);
      walk_d = DEC_W'(d);
      if (done) drawing = 1'b0;
      for (int k = 0; k < 8; k++) begin
        p.pos_x      = PIX_W'(px[k]);
        p.pos_y      = PIX_W'(py[k]);
        p.color      = pen;
        p.octant     = OCT_W'(k);
        p.step_end   = (p.octant == crast_pkg::OCT_LAST);
        p.circle_end = p.step_end && done;
        pixels_due.push_back(p);
      end
      steps_drawn++;
    end
  endtask

  // Offer one item in bursts with random gaps; predict on transfer
  task automatic send_item(input logic op, input logic [COORD_BITS-1:0] cx,
                           input logic [COORD_BITS-1:0] cy,
                           input logic [COORD_BITS-1:0] r);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_center_x <= cx;
    in_center_y <= cy;
    in_radius   <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    walk_circle(op, cx, cy, r);
  endtask

  task automatic send_step();
    send_item(crast_pkg::OP_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
              COORD_BITS'($urandom));
  endtask

  // Drop valid and hold until every pixel has arrived and the block settles
  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_pen(input logic [COLOR_W-1:0] color);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= color;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    pen = color;
  endtask

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pixels_due.size() == 0) begin
        $display("%0t ns: pixel transfer with nothing expected, actual (%0d,%0d) octant %0d",
                 $time, out_pixel_x, out_pixel_y, out_octant);
        mismatches++;
      end else begin
        want = pixels_due.pop_front();
        check_field("pixel_x", want.pos_x, out_pixel_x);
        check_field("pixel_y", want.pos_y, out_pixel_y);
        check_field("pixel_color", want.color, out_pixel_color);
        check_field("octant", want.octant, out_octant);
        check_field("last_of_step", want.step_end, out_last_of_step);
        check_field("last_of_circle", want.circle_end, out_last_of_circle);
        pixels_checked++;
      end
    end
  end

  // Receiver: long hold on request, otherwise a stall mode that changes now and then
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req != hold_taken) begin
      hold_taken <= hold_taken + 1;
      hold_left  <= HOLD_CYCLES;
      out_ready  <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        sink_mode <= sink_mode_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(16, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      ready_pat <= {ready_pat[0], ready_pat[4:1]};
      case (sink_mode)
        SINK_FULL:    out_ready <= 1'b1;
        SINK_RANDOM:  out_ready <= $urandom_range(0, 1);
        SINK_PATTERN: out_ready <= ready_pat[0];
        default:      out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Reset pen color, step while idle, zero radius
  task automatic test_idle_and_zero_radius();
    send_step();
    send_item(crast_pkg::OP_START, '0, '0, '0);
    send_step();
    send_step();
    wait_idle();
  endtask

  // Corner centers, negative pixels, abandoned large circle, diagonal duplicates
  task automatic test_corner_circles();
    send_item(crast_pkg::OP_START, '1, '1, 10'd1);
    send_step();
    send_item(crast_pkg::OP_START, '0, '0, 10'd5);
    repeat (3) send_step();
    send_item(crast_pkg::OP_START, '1, '0, '1);
    repeat (2) send_step();
    send_item(crast_pkg::OP_START, '0, '1, 10'd3);
    while (drawing) send_step();
    wait_idle();
  endtask

  // Mostly full circles of small radius; some large ones cut short; stray steps
  task automatic test_random_circles(input int unsigned target);
    int unsigned sent;
    int unsigned kind;
    sent = 0;
    while (sent < target) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        if (!drawing) send_step();
      end else if (kind == 1) begin
        send_item(crast_pkg::OP_START, COORD_BITS'($urandom), COORD_BITS'($urandom),
                  COORD_BITS'($urandom_range(512, 1023)));
        sent++;
        repeat ($urandom_range(1, 6)) begin
          send_step();
          sent++;
        end
      end else begin
        send_item(crast_pkg::OP_START, COORD_BITS'($urandom), COORD_BITS'($urandom),
                  COORD_BITS'($urandom_range(0, 24)));
        sent++;
        while (drawing) begin
          send_step();
          sent++;
        end
      end
    end
    wait_idle();
  endtask

  // Hold the receiver off while steps keep coming, so the block stalls its input
  task automatic test_output_backpressure();
    wait_idle();
    hold_req <= hold_req + 1;
    send_item(crast_pkg::OP_START, 10'd512, 10'd512, 10'd200);
    repeat (30) send_step();
    wait_idle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_and_zero_radius();
    test_corner_circles();
    set_pen('0);
    test_random_circles(90);
    set_pen('1);
    test_random_circles(90);
    test_output_backpressure();
    set_pen(COLOR_W'($urandom_range(1, 14)));
    test_random_circles(90);
    wait_idle();
    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d items: %0d circles started, %0d steps drawn, %0d pixels checked",
             items_sent, circles_started, steps_drawn, pixels_checked);
    $display("Covered reset, low, high and random pen colors and a %0d-cycle output hold",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
